@@ rtl/sma_crossover_signal_top_defines.svh @@
// Assertion macros for the moving average crossover block.
// Used by the checker; expects clk and rst in the scope of each use.
`ifndef SMA_CROSSOVER_SIGNAL_TOP_DEFINES_SVH
`define SMA_CROSSOVER_SIGNAL_TOP_DEFINES_SVH

// same-cycle implication
`define SMAC_ASSERT_SAME(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication
`define SMAC_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

@@ rtl/smac_pkg.sv @@
// Shared types and constants for the moving average crossover block.
// No dependencies.
`timescale 1ns / 1ps

package smac_pkg;

  localparam int DEF_MAX_WINDOW = 256;
  localparam int DEF_PRICE_BITS = 32;

  localparam int CFG_BITS       = 9;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_BITS-1:0] SHORT_WINDOW_RESET = 9'd5;
  localparam logic [CFG_BITS-1:0] LONG_WINDOW_RESET  = 9'd20;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SHORT_WINDOW = 2'd0,
    REG_LONG_WINDOW  = 2'd1
  } cfg_reg_t;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  // per-cell shift control
  typedef struct packed {
    logic shift;
    logic load_short;
    logic load_long;
  } cell_ctrl_t;

  // control into the decision stage
  typedef struct packed {
    logic valid;
    logic warm;
    logic clear_run;
  } dec_ctrl_t;

endpackage

@@ rtl/smac_cell.sv @@
// One cell of the price delay chains: a short lane and a long lane.
// Depends on smac_pkg.
`timescale 1ns / 1ps

module smac_cell
  import smac_pkg::*;
#(
  parameter int PRICE_BITS = DEF_PRICE_BITS
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [PRICE_BITS-1:0] price,
  input  logic [PRICE_BITS-1:0] short_prev,
  input  logic [PRICE_BITS-1:0] long_prev,
  output logic [PRICE_BITS-1:0] short_q,
  output logic [PRICE_BITS-1:0] long_q
);

  // a new price enters at the cell picked by the window length and
  // leaves the end of the chain exactly that many words later
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      short_q <= ctrl.load_short ? price : short_prev;
      long_q  <= ctrl.load_long  ? price : long_prev;
    end
  end

endmodule

@@ rtl/smac_decide.sv @@
// Crossover decision stage with position state and output register.
// Depends on smac_pkg.
`timescale 1ns / 1ps

module smac_decide
  import smac_pkg::*;
#(
  parameter int PROD_BITS = 49
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dec_ctrl_t            ctrl,
  input  logic [PROD_BITS-1:0] prod_short,
  input  logic [PROD_BITS-1:0] prod_long,
  output logic                 take,
  output logic                 order_valid,
  input  logic                 order_ready,
  output logic                 order_side
);

  logic prev_short_above;
  logic holding_position;
  logic cur_above;
  logic fire_buy;
  logic fire_sell;

  always_comb begin
    take      = ctrl.valid && (!order_valid || order_ready);
    cur_above = prod_short > prod_long;
    fire_buy  = ctrl.warm && !prev_short_above && cur_above && !holding_position;
    fire_sell = ctrl.warm && prev_short_above && !cur_above && holding_position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_short_above <= 1'b0;
      holding_position <= 1'b0;
      order_valid      <= 1'b0;
    end else begin
      if (ctrl.clear_run) begin
        prev_short_above <= 1'b0;
      end
      if (take) begin
        prev_short_above <= cur_above;
        if (fire_buy || fire_sell) begin
          holding_position <= fire_buy;
        end
        order_valid <= fire_buy || fire_sell;
      end else if (order_ready) begin
        order_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && (fire_buy || fire_sell)) begin
      order_side <= fire_sell ? SIDE_SELL : SIDE_BUY;
    end
  end

endmodule

@@ rtl/sma_crossover_signal_top.sv @@
// Moving average crossover: two delay chains of cells, running sums,
// cross-multiply compare and order output. Depends on smac_pkg, smac_cell, smac_decide.
// Sum, product, then order register; 1 word per cycle unless order_ready stalls.
// Rate is set by the registered sum update and one shift of the cell chains per word.
// Reset clears sums, bar count, trend and position flags and the stage valids;
// windows return to 5 and 20. Chain contents need no clearing.
`timescale 1ns / 1ps

module sma_crossover_signal_top
  import smac_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int PRICE_BITS = DEF_PRICE_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      price_valid,
  output logic                      price_ready,
  input  logic [PRICE_BITS-1:0]     close_price,
  output logic                      order_valid,
  input  logic                      order_ready,
  output logic                      order_side,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_wr_data
);

  localparam int WIN_BITS  = $clog2(MAX_WINDOW + 1);
  localparam int IDX_BITS  = $clog2(MAX_WINDOW);
  localparam int CNT_BITS  = $clog2(MAX_WINDOW + 2);
  localparam int SUM_BITS  = PRICE_BITS + $clog2(MAX_WINDOW);
  localparam int PROD_BITS = SUM_BITS + WIN_BITS;

  logic [CFG_BITS-1:0]   short_window;
  logic [CFG_BITS-1:0]   long_window;
  logic [WIN_BITS-1:0]   s_eff;
  logic [WIN_BITS-1:0]   l_eff;
  logic [WIN_BITS-1:0]   win_max;
  logic [CNT_BITS-1:0]   need;
  logic [IDX_BITS-1:0]   short_load_idx;
  logic [IDX_BITS-1:0]   long_load_idx;
  logic                  clear_run;

  logic [PRICE_BITS-1:0] short_tap [MAX_WINDOW];
  logic [PRICE_BITS-1:0] long_tap  [MAX_WINDOW];

  logic [SUM_BITS-1:0]   short_sum;
  logic [SUM_BITS-1:0]   long_sum;
  logic [SUM_BITS-1:0]   short_sum_next;
  logic [SUM_BITS-1:0]   long_sum_next;
  logic [PRICE_BITS-1:0] short_drop;
  logic [PRICE_BITS-1:0] long_drop;
  logic [CNT_BITS-1:0]   bars_seen;
  logic [CNT_BITS-1:0]   bars_seen_next;

  logic                  price_acc;
  logic                  a_valid;
  logic                  a_warm;
  logic                  a_move;
  logic                  b_valid;
  logic                  b_warm;
  logic                  b_move;
  logic [PROD_BITS-1:0]  prod_short;
  logic [PROD_BITS-1:0]  prod_long;
  dec_ctrl_t             dec_ctrl;

  // configuration
  always_comb begin
    clear_run = 1'b0;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_SHORT_WINDOW: clear_run = 1'b1;
        REG_LONG_WINDOW:  clear_run = 1'b1;
        default:          clear_run = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_window <= SHORT_WINDOW_RESET;
      long_window  <= LONG_WINDOW_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SHORT_WINDOW: short_window <= cfg_wr_data;
        REG_LONG_WINDOW:  long_window  <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // clamp windows to 1..MAX_WINDOW
  always_comb begin
    if (short_window == '0) begin
      s_eff = WIN_BITS'(1);
    end else if (int'(short_window) > MAX_WINDOW) begin
      s_eff = WIN_BITS'(MAX_WINDOW);
    end else begin
      s_eff = WIN_BITS'(short_window);
    end
    if (long_window == '0) begin
      l_eff = WIN_BITS'(1);
    end else if (int'(long_window) > MAX_WINDOW) begin
      l_eff = WIN_BITS'(MAX_WINDOW);
    end else begin
      l_eff = WIN_BITS'(long_window);
    end
    win_max        = (s_eff > l_eff) ? s_eff : l_eff;
    need           = CNT_BITS'(win_max) + CNT_BITS'(1);
    short_load_idx = IDX_BITS'(WIN_BITS'(MAX_WINDOW) - s_eff);
    long_load_idx  = IDX_BITS'(WIN_BITS'(MAX_WINDOW) - l_eff);
  end

  // delay chains
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    cell_ctrl_t            cctrl;
    logic [PRICE_BITS-1:0] short_in;
    logic [PRICE_BITS-1:0] long_in;

    assign cctrl.shift      = price_acc;
    assign cctrl.load_short = (short_load_idx == IDX_BITS'(i));
    assign cctrl.load_long  = (long_load_idx == IDX_BITS'(i));

    if (i == 0) begin : g_head
      assign short_in = close_price;
      assign long_in  = close_price;
    end else begin : g_body
      assign short_in = short_tap[i-1];
      assign long_in  = long_tap[i-1];
    end

    smac_cell #(
      .PRICE_BITS(PRICE_BITS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cctrl),
      .price     (close_price),
      .short_prev(short_in),
      .long_prev (long_in),
      .short_q   (short_tap[i]),
      .long_q    (long_tap[i])
    );
  end

  // pipeline flow
  always_comb begin
    a_move      = a_valid && (!b_valid || b_move);
    price_ready = !a_valid || a_move;
    price_acc   = price_valid && price_ready;
  end

  // running sums; the word leaving each window sits at the chain end
  always_comb begin
    short_drop     = (bars_seen >= CNT_BITS'(s_eff)) ? short_tap[MAX_WINDOW-1] : '0;
    long_drop      = (bars_seen >= CNT_BITS'(l_eff)) ? long_tap[MAX_WINDOW-1] : '0;
    short_sum_next = short_sum - SUM_BITS'(short_drop) + SUM_BITS'(close_price);
    long_sum_next  = long_sum - SUM_BITS'(long_drop) + SUM_BITS'(close_price);
    bars_seen_next = (bars_seen < need) ? bars_seen + CNT_BITS'(1) : bars_seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_sum <= '0;
      long_sum  <= '0;
      bars_seen <= '0;
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
    end else begin
      if (clear_run) begin
        short_sum <= '0;
        long_sum  <= '0;
        bars_seen <= '0;
      end else if (price_acc) begin
        short_sum <= short_sum_next;
        long_sum  <= long_sum_next;
        bars_seen <= bars_seen_next;
      end
      if (price_acc) begin
        a_valid <= 1'b1;
      end else if (a_move) begin
        a_valid <= 1'b0;
      end
      if (a_move) begin
        b_valid <= 1'b1;
      end else if (b_move) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (price_acc) begin
      a_warm <= bars_seen_next >= need;
    end
  end

  // exact mean compare: short_sum * l against long_sum * s
  always_ff @(posedge clk) begin
    if (a_move) begin
      prod_short <= PROD_BITS'(short_sum) * PROD_BITS'(l_eff);
      prod_long  <= PROD_BITS'(long_sum) * PROD_BITS'(s_eff);
      b_warm     <= a_warm;
    end
  end

  assign dec_ctrl.valid     = b_valid;
  assign dec_ctrl.warm      = b_warm;
  assign dec_ctrl.clear_run = clear_run;

  smac_decide #(
    .PROD_BITS(PROD_BITS)
  ) u_decide (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (dec_ctrl),
    .prod_short (prod_short),
    .prod_long  (prod_long),
    .take       (b_move),
    .order_valid(order_valid),
    .order_ready(order_ready),
    .order_side (order_side)
  );

endmodule

@@ rtl/smac_checker.sv @@
// Port-level checks for the crossover block, bound to the top level.
// Depends on smac_pkg and sma_crossover_signal_top_defines.svh.
`timescale 1ns / 1ps
`include "sma_crossover_signal_top_defines.svh"

module smac_checker
  import smac_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      price_valid,
  input logic                      price_ready,
  input logic                      order_valid,
  input logic                      order_ready,
  input logic                      order_side,
  input logic                      cfg_wr_en,
  input logic [CFG_INDEX_BITS-1:0] cfg_index
);

  logic [1:0] warm_cnt;
  logic       expect_side;

  // words since reset or a window write, saturating at two
  always_ff @(posedge clk) begin
    if (rst) begin
      warm_cnt    <= '0;
      expect_side <= SIDE_BUY;
    end else begin
      if (cfg_wr_en && (cfg_index == REG_SHORT_WINDOW || cfg_index == REG_LONG_WINDOW)) begin
        warm_cnt <= '0;
      end else if (price_valid && price_ready && warm_cnt != 2'd2) begin
        warm_cnt <= warm_cnt + 2'd1;
      end
      if (order_valid && order_ready) begin
        expect_side <= ~expect_side;
      end
    end
  end

  `SMAC_ASSERT_NEXT(a_order_hold, order_valid && !order_ready, order_valid && $stable(order_side), "order word changed while stalled")
  `SMAC_ASSERT_SAME(a_side_alternates, order_valid, order_side == expect_side, "orders must alternate starting with a buy")
  `SMAC_ASSERT_SAME(a_warmup, order_valid, warm_cnt == 2'd2, "order issued before two prices seen")

endmodule

bind sma_crossover_signal_top smac_checker u_smac_checker (.*);
